// ----- src/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer to ASCII formatter
// Format codes, item types, sequencer states and the character lookup.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int DEC_BITS_DEF   = 32;

  localparam int FUNC_W       = 3;
  localparam int WORD_W       = 64;
  localparam int CHAR_W       = 8;
  localparam int NIBBLE_W     = 4;
  localparam int DIGIT_SLOTS  = WORD_W / NIBBLE_W;
  localparam int SLOT_CNT_W   = 5;
  localparam int BCD_DIGITS   = 10;
  localparam int BCD_BITS     = BCD_DIGITS * NIBBLE_W;

  localparam logic [FUNC_W-1:0] FUNC_HEX_LOWER = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_HEX_UPPER = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEC_SIGNED = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEC_UNSIGNED = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_POINTER = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] value;
  } i2a_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } i2a_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DABBLE,
    S_SKIP,
    S_PREFIX0,
    S_PREFIX1,
    S_DIGITS
  } i2a_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [NIBBLE_W-1:0] nib,
                                                   input logic upper);
    logic [CHAR_W-1:0] wide;
    wide = {{(CHAR_W-NIBBLE_W){1'b0}}, nib};
    if (nib < 4'd10) begin
      digit_char = CHAR_ZERO + wide;
    end else if (upper) begin
      digit_char = CHAR_UPPER_A + wide - 8'd10;
    end else begin
      digit_char = CHAR_LOWER_A + wide - 8'd10;
    end
  endfunction

endpackage

// ----- src/i2a_bcd.sv -----
// ----------------------------------------------------------------------------
// i2a_bcd: binary to BCD converter
// Shift-and-add-three conversion, one input bit per clock cycle.
// ----------------------------------------------------------------------------
module i2a_bcd #(
  parameter int DEC_BITS = i2a_pkg::DEC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [DEC_BITS-1:0]          bin,
  output logic                         done,
  output logic [i2a_pkg::BCD_BITS-1:0] bcd
);
  import i2a_pkg::*;

  localparam int CNT_W = $clog2(DEC_BITS + 1);

  logic [DEC_BITS-1:0] sreg;
  logic [CNT_W-1:0]    cnt;
  logic                running;
  logic [BCD_BITS-1:0] adj;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*NIBBLE_W +: NIBBLE_W] >= 4'd5) begin
        adj[i*NIBBLE_W +: NIBBLE_W] = bcd[i*NIBBLE_W +: NIBBLE_W] + 4'd3;
      end else begin
        adj[i*NIBBLE_W +: NIBBLE_W] = bcd[i*NIBBLE_W +: NIBBLE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DEC_BITS);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sreg <= bin;
      bcd  <= '0;
    end else if (running) begin
      bcd  <= {adj[BCD_BITS-2:0], sreg[DEC_BITS-1]};
      sreg <= {sreg[DEC_BITS-2:0], 1'b0};
    end
  end

endmodule

// ----- src/integer_to_ascii_formatter_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core: number to ASCII character formatter
// Prints one number in hex, decimal or pointer form, one character per strobe.
// ----------------------------------------------------------------------------
//  channel  | ports                        | handshake
//  ---------+------------------------------+-------------------------------
//  input    | request (func, value)        | start high while busy is low
//  output   | result (char_out, last)      | strobe high once per character
//
// A hex item first discards leading zero digits, keeping at least one, then
// emits the "0x" prefix for a pointer and one character per digit. A decimal
// item first passes through the shift-and-add-three converter, then discards
// leading zero digits, emits a minus sign when negative and one character per
// digit. A new item can be taken in the cycle after the last character.
// Synchronous reset returns the sequencer to idle. Results cannot be stalled.
module integer_to_ascii_formatter_core #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF,
  parameter int DEC_BITS   = i2a_pkg::DEC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  i2a_pkg::i2a_in_t  request,
  output logic              strobe,
  output i2a_pkg::i2a_out_t result
);
  import i2a_pkg::*;

  localparam logic [WORD_W-1:0] VMASK = {WORD_W{1'b1}} >> (WORD_W - VALUE_BITS);

  i2a_state_t            state, state_next;
  logic [WORD_W-1:0]     digits;
  logic [SLOT_CNT_W-1:0] cnt;
  logic                  upper;
  logic                  ptr;
  logic                  neg;

  logic                  accept;
  logic                  is_hex;
  logic                  is_dec;
  logic [DEC_BITS-1:0]   dec_raw;
  logic                  dec_neg;
  logic [DEC_BITS-1:0]   dec_mag;
  logic                  bcd_done;
  logic [BCD_BITS-1:0]   bcd;
  logic                  top_zero;

  assign accept  = start && (state == S_IDLE);
  assign is_hex  = (request.func == FUNC_HEX_LOWER) || (request.func == FUNC_HEX_UPPER) ||
                   (request.func == FUNC_POINTER);
  assign is_dec  = (request.func == FUNC_DEC_SIGNED) ||
                   (request.func == FUNC_DEC_UNSIGNED);
  assign dec_raw = request.value[DEC_BITS-1:0];
  assign dec_neg = (request.func == FUNC_DEC_SIGNED) && dec_raw[DEC_BITS-1];
  assign dec_mag = dec_neg ? (~dec_raw + 1'b1) : dec_raw;
  assign top_zero = (digits[WORD_W-1 -: NIBBLE_W] == '0);

  i2a_bcd #(
    .DEC_BITS(DEC_BITS)
  ) u_bcd (
    .clk  (clk),
    .rst  (rst),
    .start(accept && is_dec),
    .bin  (dec_mag),
    .done (bcd_done),
    .bcd  (bcd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && is_hex) begin
          state_next = S_SKIP;
        end else if (accept && is_dec) begin
          state_next = S_DABBLE;
        end
      end
      S_DABBLE: begin
        if (bcd_done) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (!(top_zero && (cnt > SLOT_CNT_W'(1)))) begin
          state_next = (ptr || neg) ? S_PREFIX0 : S_DIGITS;
        end
      end
      S_PREFIX0: begin
        state_next = ptr ? S_PREFIX1 : S_DIGITS;
      end
      S_PREFIX1: begin
        state_next = S_DIGITS;
      end
      S_DIGITS: begin
        if (cnt == SLOT_CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy            = (state != S_IDLE);
    strobe          = 1'b0;
    result.char_out = digit_char(digits[WORD_W-1 -: NIBBLE_W], upper);
    result.last     = 1'b0;
    unique case (state)
      S_IDLE, S_DABBLE, S_SKIP: begin
        strobe = 1'b0;
      end
      S_PREFIX0: begin
        strobe          = 1'b1;
        result.char_out = neg ? CHAR_MINUS : CHAR_ZERO;
      end
      S_PREFIX1: begin
        strobe          = 1'b1;
        result.char_out = CHAR_X;
      end
      S_DIGITS: begin
        strobe      = 1'b1;
        result.last = (cnt == SLOT_CNT_W'(1));
      end
      default: begin
        strobe = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          upper  <= (request.func == FUNC_HEX_UPPER);
          ptr    <= (request.func == FUNC_POINTER);
          neg    <= dec_neg;
          cnt    <= SLOT_CNT_W'(DIGIT_SLOTS);
          digits <= request.value & VMASK;
        end
      end
      S_DABBLE: begin
        if (bcd_done) begin
          digits <= {{(WORD_W-BCD_BITS){1'b0}}, bcd};
        end
      end
      S_SKIP: begin
        if (top_zero && (cnt > SLOT_CNT_W'(1))) begin
          digits <= {digits[WORD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
          cnt    <= cnt - 1'b1;
        end
      end
      S_PREFIX0, S_PREFIX1: begin
        cnt <= cnt;
      end
      S_DIGITS: begin
        digits <= {digits[WORD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
        cnt    <= cnt - 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

// ----- src/i2a_checker.sv -----
// ----------------------------------------------------------------------------
// i2a_checker: port-level checks of the formatter
// Watches the handshake and framing of characters over time.
// ----------------------------------------------------------------------------
module i2a_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input i2a_pkg::i2a_in_t  request,
  input logic              strobe,
  input i2a_pkg::i2a_out_t result
);
  import i2a_pkg::*;

  // Characters only appear while an item is being worked on.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("character emitted while idle");

  // The characters of one item form an unbroken burst.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |=> strobe) else $error("gap inside a character burst");

  // The final character of an item releases the block.
  a_last_free: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !busy) else $error("still busy after last character");

  // A valid format code starts work; an unused code is dropped.
  a_valid_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.func <= FUNC_POINTER)) |=> busy)
    else $error("valid item not taken");

  a_unused_code: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.func > FUNC_POINTER)) |=> !busy)
    else $error("unused format code started work");

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (.*);
